### hdl/cca_pkg.sv
// Package for the concurrent call admission block.
// Holds the request and response payload types, the status and request codes,
// and the command and status structs between the controller and the datapath.
package cca_pkg;

	// Request codes.
	localparam logic REQ_ADMIT   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	// Response status codes.
	localparam logic [2:0] STAT_NEW      = 3'd0;
	localparam logic [2:0] STAT_BRANCH   = 3'd1;
	localparam logic [2:0] STAT_LIMIT    = 3'd2;
	localparam logic [2:0] STAT_FULL     = 3'd3;
	localparam logic [2:0] STAT_BR_REL   = 3'd4;
	localparam logic [2:0] STAT_CALL_REL = 3'd5;

	// Saturation value of the account and branch counters.
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// One admission or release request.
	typedef struct packed {
		logic        req_type;
		logic [7:0]  account_id;
		logic [31:0] call_tag;
		logic [15:0] call_limit;
	} req_t;

	// One response.
	typedef struct packed {
		logic        accepted;
		logic [2:0]  status;
		logic [15:0] active_calls;
		logic [15:0] branch_count;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic scan_last;
	} ctl_sts_t;

endpackage

### hdl/cca_ctrl.sv
// Controller state machine of the concurrent call admission block.
// Sequences the clearing pass, the request load, the call table scan and the commit.
// Depends on cca_pkg for the command and status structs.
module cca_ctrl import cca_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd,
	output logic     busy
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_DECIDE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// Next state and command decode.
	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.commit = 1'b1;
				state_nxt  = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

### hdl/cca_datapath.sv
// Datapath of the concurrent call admission block: account count memory,
// call table memories, scan compare, admission decision and response register.
// Depends on cca_pkg for payload types, codes and the controller structs.
module cca_datapath import cca_pkg::*; #(
	parameter int ACCOUNTS     = 256,
	parameter int CALL_ENTRIES = 64,
	parameter int TAG_BITS     = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_cmd_t cmd,
	output ctl_sts_t sts,
	input  req_t     req,
	input  logic     cfg_valid,
	input  logic     cfg_data,
	output logic     done,
	output rsp_t     rsp
);

	localparam int AW    = $clog2(ACCOUNTS);
	localparam int EW    = $clog2(CALL_ENTRIES);
	localparam int TW    = (TAG_BITS < 32) ? TAG_BITS : 32;
	localparam int CLR_N = (ACCOUNTS > CALL_ENTRIES) ? ACCOUNTS : CALL_ENTRIES;
	localparam int CW    = $clog2(CLR_N);

	// Memories.
	logic [15:0]   acct_mem [ACCOUNTS];
	logic          ent_vld_mem [CALL_ENTRIES];
	logic [AW-1:0] ent_acct_mem [CALL_ENTRIES];
	logic [TW-1:0] ent_tag_mem [CALL_ENTRIES];
	logic [15:0]   ent_br_mem [CALL_ENTRIES];

	// Request registers.
	logic          req_type_q;
	logic [AW-1:0] acct_q;
	logic [TW-1:0] tag_q;
	logic [15:0]   limit_q;
	logic          strict_q;

	// Scan and clear state.
	logic [CW-1:0] clr_idx_q;
	logic [EW-1:0] scan_idx_q;
	logic          rd_vld_s1;
	logic [EW-1:0] rd_idx_s1;
	logic          ent_vld_s1;
	logic [AW-1:0] ent_acct_s1;
	logic [TW-1:0] ent_tag_s1;
	logic [15:0]   ent_br_s1;
	logic [15:0]   cnt_s1;
	logic          hit_q;
	logic [EW-1:0] hit_idx_q;
	logic [15:0]   hit_br_q;
	logic          free_q;
	logic [EW-1:0] free_idx_q;

	// Decision signals.
	logic [31:0]   acct_rem;
	logic [AW-1:0] acct_idx;
	logic          clr_acct;
	logic          clr_ent;
	logic          acct_we;
	logic [15:0]   cnt_new;
	logic          ent_we;
	logic [EW-1:0] ent_idx;
	logic          ent_vld_new;
	logic [15:0]   ent_br_new;
	rsp_t          rsp_nxt;
	logic          done_q;
	rsp_t          rsp_q;

	// Account index: the 8-bit id reduced by restoring subtraction of the shifted count.
	always_comb begin
		acct_rem = 32'(req.account_id);
		if (ACCOUNTS < 256) begin
			for (int k = 7; k >= 0; k--) begin
				if ((ACCOUNTS << k) <= 255 && acct_rem >= 32'(ACCOUNTS << k)) begin
					acct_rem = acct_rem - 32'(ACCOUNTS << k);
				end
			end
		end
	end
	assign acct_idx = acct_rem[AW-1:0];

	// Clearing pass bookkeeping.
	assign clr_acct = ({{(32-CW){1'b0}}, clr_idx_q} < 32'(ACCOUNTS));
	assign clr_ent  = ({{(32-CW){1'b0}}, clr_idx_q} < 32'(CALL_ENTRIES));
	assign sts.clear_last = (clr_idx_q == CW'(CLR_N - 1));
	assign sts.scan_last  = (scan_idx_q == EW'(CALL_ENTRIES - 1));

	// Admission decision, evaluated in the commit cycle.
	always_comb begin
		acct_we     = 1'b0;
		cnt_new     = cnt_s1;
		ent_we      = 1'b0;
		ent_idx     = hit_idx_q;
		ent_vld_new = 1'b1;
		ent_br_new  = 16'd1;
		rsp_nxt     = '0;
		if (req_type_q == REQ_ADMIT) begin
			if (hit_q && !strict_q) begin
				// Known call gains a branch.
				ent_we     = 1'b1;
				ent_br_new = (hit_br_q < CNT_MAX) ? hit_br_q + 16'd1 : hit_br_q;
				rsp_nxt.accepted     = 1'b1;
				rsp_nxt.status       = STAT_BRANCH;
				rsp_nxt.branch_count = ent_br_new;
			end else if (cnt_s1 >= limit_q) begin
				rsp_nxt.status       = STAT_LIMIT;
				rsp_nxt.branch_count = hit_q ? hit_br_q : 16'd0;
			end else if (!hit_q && !free_q) begin
				rsp_nxt.status = STAT_FULL;
			end else begin
				// New call, or a strict admit reusing the known entry.
				ent_idx = hit_q ? hit_idx_q : free_idx_q;
				ent_we  = 1'b1;
				acct_we = 1'b1;
				cnt_new = (cnt_s1 < CNT_MAX) ? cnt_s1 + 16'd1 : cnt_s1;
				rsp_nxt.accepted     = 1'b1;
				rsp_nxt.status       = STAT_NEW;
				rsp_nxt.branch_count = 16'd1;
			end
		end else begin
			if (hit_q && hit_br_q > 16'd1) begin
				ent_we     = 1'b1;
				ent_br_new = hit_br_q - 16'd1;
				rsp_nxt.status       = STAT_BR_REL;
				rsp_nxt.branch_count = ent_br_new;
			end else begin
				// Whole call released; an unknown call still lowers the count.
				ent_we      = hit_q;
				ent_vld_new = 1'b0;
				acct_we     = 1'b1;
				cnt_new     = (cnt_s1 != 16'd0) ? cnt_s1 - 16'd1 : cnt_s1;
				rsp_nxt.accepted = 1'b1;
				rsp_nxt.status   = STAT_CALL_REL;
			end
		end
		rsp_nxt.active_calls = cnt_new;
	end

	// Account count memory: clear sweep or commit write, read at load.
	always_ff @(posedge clk) begin
		if (cmd.clear && clr_acct) begin
			acct_mem[clr_idx_q[AW-1:0]] <= 16'd0;
		end else if (cmd.commit && acct_we) begin
			acct_mem[acct_q] <= cnt_new;
		end
		if (cmd.load) begin
			cnt_s1 <= acct_mem[acct_idx];
		end
	end

	// Call table valid memory: cleared by the sweep, written at commit, read during the scan.
	always_ff @(posedge clk) begin
		if (cmd.clear && clr_ent) begin
			ent_vld_mem[clr_idx_q[EW-1:0]] <= 1'b0;
		end else if (cmd.commit && ent_we) begin
			ent_vld_mem[ent_idx] <= ent_vld_new;
		end
		if (cmd.scan) begin
			ent_vld_s1 <= ent_vld_mem[scan_idx_q];
		end
	end

	// Call table payload memories.
	always_ff @(posedge clk) begin
		if (cmd.commit && ent_we) begin
			ent_acct_mem[ent_idx] <= acct_q;
			ent_tag_mem[ent_idx]  <= tag_q;
			ent_br_mem[ent_idx]   <= ent_br_new;
		end
		if (cmd.scan) begin
			ent_acct_s1 <= ent_acct_mem[scan_idx_q];
			ent_tag_s1  <= ent_tag_mem[scan_idx_q];
			ent_br_s1   <= ent_br_mem[scan_idx_q];
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req.req_type;
			acct_q     <= acct_idx;
			tag_q      <= req.call_tag[TW-1:0];
			limit_q    <= req.call_limit;
		end
	end

	// Scan payload registers and the response register.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
		if (rd_vld_s1 && ent_vld_s1 && ent_acct_s1 == acct_q && ent_tag_s1 == tag_q) begin
			hit_idx_q <= rd_idx_s1;
			hit_br_q  <= ent_br_s1;
		end
		if (rd_vld_s1 && !ent_vld_s1 && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_nxt;
		end
	end

	// Control registers: counters, match flags, strict mode, done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			strict_q   <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_idx_q <= clr_idx_q + CW'(1);
			end
			if (cmd.load) begin
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
			end else begin
				if (cmd.scan) begin
					scan_idx_q <= scan_idx_q + EW'(1);
				end
				if (rd_vld_s1 && ent_vld_s1 && ent_acct_s1 == acct_q && ent_tag_s1 == tag_q) begin
					hit_q <= 1'b1;
				end
				if (rd_vld_s1 && !ent_vld_s1) begin
					free_q <= 1'b1;
				end
			end
			rd_vld_s1 <= cmd.scan;
			if (cfg_valid) begin
				strict_q <= cfg_data;
			end
			done_q <= cmd.commit;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### hdl/concurrent_call_admission.sv
// Concurrent call admission, top level: controller and datapath.
// A transaction accepted at a clock edge gives its response on done after the
// load, the table scan, the drain and the decide step; the next start is taken in the
// cycle done is high, and the table scan reads one entry a cycle.
// Reset: busy stays high for the clearing pass over both memories; the
// receiver cannot stall, each response is valid for the single cycle done is high.
module concurrent_call_admission import cca_pkg::*; #(
	parameter int ACCOUNTS     = 256,
	parameter int CALL_ENTRIES = 64,
	parameter int TAG_BITS     = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// The strict mode register is always writable.
	assign cfg_ready = 1'b1;

	// Sequencer.
	cca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Memories and decision logic.
	cca_datapath #(
		.ACCOUNTS     (ACCOUNTS),
		.CALL_ENTRIES (CALL_ENTRIES),
		.TAG_BITS     (TAG_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.done      (done),
		.rsp       (rsp)
	);

	// The controller issues at most one command per cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.load, cmd.scan, cmd.commit}))
		else $error("more than one controller command active");

	// An accepted transaction makes the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// A response only follows a busy cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("response without a transaction in progress");

	// A new call is always granted with exactly one branch.
	a_new_call: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == STAT_NEW) |-> (rsp.accepted && rsp.branch_count == 16'd1))
		else $error("new call response malformed");

endmodule

### dv/tb_top.sv
// Self-checking testbench for the concurrent call admission block.
// Depends on cca_pkg for the request, response and status codes; it keeps its own
// copy of the account and call tables to predict every response.
module tb_top import cca_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ACCOUNTS     = 256;
	localparam int CALL_ENTRIES = 64;
	localparam int TAG_BITS     = 32;
	// One transaction takes a full table scan plus the load, drain and decide steps.
	localparam int SETTLE_CYCLES = CALL_ENTRIES + 3 + 16;
	localparam int HANG_LIMIT    = 2000;
	localparam int REPORT_MAX    = 10;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;

	// Predicted state of the block.
	bit [15:0] acct_calls [ACCOUNTS];
	bit        slot_used [CALL_ENTRIES];
	bit [7:0]  slot_acct [CALL_ENTRIES];
	bit [31:0] slot_tag [CALL_ENTRIES];
	bit [15:0] slot_branches [CALL_ENTRIES];
	bit        strict_calls;

	rsp_t pending_rsp [$];
	int   mismatches;
	int   sender_idle_pct;
	int   idle_cycles;

	concurrent_call_admission #(
		.ACCOUNTS(ACCOUNTS),
		.CALL_ENTRIES(CALL_ENTRIES),
		.TAG_BITS(TAG_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Free-running clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predicts the response of one admit or release and updates the tables.
	function automatic rsp_t predict_admission(req_t r);
		int   hit;
		int   slot;
		rsp_t o;
		hit = -1;
		slot = -1;
		o = '0;
		for (int i = 0; i < CALL_ENTRIES; i++) begin
			if (hit < 0 && slot_used[i] && slot_acct[i] == r.account_id &&
					slot_tag[i] == r.call_tag)
				hit = i;
		end
		if (r.req_type == REQ_ADMIT) begin
			if (hit >= 0 && !strict_calls) begin
				// A known call only gains a branch, whatever the limit.
				if (slot_branches[hit] != CNT_MAX)
					slot_branches[hit]++;
				o.accepted = 1'b1;
				o.status = STAT_BRANCH;
				o.branch_count = slot_branches[hit];
			end else if (acct_calls[r.account_id] >= r.call_limit) begin
				o.status = STAT_LIMIT;
				o.branch_count = (hit >= 0) ? slot_branches[hit] : '0;
			end else begin
				// New call: reuse its own entry in strict mode, else the lowest free one.
				slot = hit;
				for (int i = 0; i < CALL_ENTRIES; i++) begin
					if (slot < 0 && !slot_used[i])
						slot = i;
				end
				if (slot < 0) begin
					o.status = STAT_FULL;
				end else begin
					if (acct_calls[r.account_id] != CNT_MAX)
						acct_calls[r.account_id]++;
					slot_used[slot] = 1'b1;
					slot_acct[slot] = r.account_id;
					slot_tag[slot] = r.call_tag;
					slot_branches[slot] = 16'd1;
					o.accepted = 1'b1;
					o.status = STAT_NEW;
					o.branch_count = 16'd1;
				end
			end
		end else begin
			if (hit >= 0 && slot_branches[hit] > 16'd1) begin
				slot_branches[hit]--;
				o.status = STAT_BR_REL;
				o.branch_count = slot_branches[hit];
			end else begin
				// The account count drops even for an unknown call, floored at zero.
				if (hit >= 0)
					slot_used[hit] = 1'b0;
				if (acct_calls[r.account_id] != 16'd0)
					acct_calls[r.account_id]--;
				o.accepted = 1'b1;
				o.status = STAT_CALL_REL;
			end
		end
		o.active_calls = acct_calls[r.account_id];
		return o;
	endfunction

	function automatic req_t call_req(logic kind, logic [7:0] acct, logic [31:0] tag,
			logic [15:0] lim);
		req_t r;
		r.req_type = kind;
		r.account_id = acct;
		r.call_tag = tag;
		r.call_limit = lim;
		return r;
	endfunction

	// Sends one request, after an optional idle gap, and records its expected response.
	// Start is left high so that a following request can go out back to back.
	task automatic send_call(req_t r);
		int gap;
		gap = 0;
		if ($urandom_range(99) < sender_idle_pct)
			gap = $urandom_range(1, 90);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_rsp.push_back(predict_admission(r));
	endtask

	// Holds the sender off until every expected response has arrived.
	task automatic hold_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Writes the strict mode register while the block is idle.
	task automatic write_strict_mode(bit strict);
		hold_until_drained();
		cfg_valid <= 1'b1;
		cfg_data <= strict;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		strict_calls = strict;
		cfg_valid <= 1'b0;
	endtask

	// Limits, unknown releases, branches and the floor at zero, one request at a time.
	task automatic test_admit_release();
		logic [7:0]  acct_lo;
		logic [7:0]  acct_hi;
		logic [31:0] tag_ones;
		logic [31:0] tag_zero;
		acct_lo = 8'h00;
		acct_hi = 8'hFF;
		tag_ones = 32'hFFFF_FFFF;
		tag_zero = 32'h0000_0000;
		write_strict_mode(1'b0);
		sender_idle_pct = 0;
		send_call(call_req(REQ_ADMIT, acct_lo, tag_zero, 16'd0));
		send_call(call_req(REQ_RELEASE, acct_lo, tag_zero, 16'd0));
		send_call(call_req(REQ_ADMIT, acct_lo, tag_ones, 16'd1));
		send_call(call_req(REQ_ADMIT, acct_lo, tag_ones, 16'd1));
		send_call(call_req(REQ_ADMIT, acct_lo, tag_zero, 16'd1));
		send_call(call_req(REQ_ADMIT, acct_lo, tag_zero, 16'hFFFF));
		send_call(call_req(REQ_RELEASE, acct_lo, tag_ones, 16'hFFFF));
		send_call(call_req(REQ_RELEASE, acct_lo, tag_ones, 16'h0000));
		send_call(call_req(REQ_RELEASE, acct_lo, tag_ones, 16'h5555));
		send_call(call_req(REQ_RELEASE, acct_lo, tag_zero, 16'hAAAA));
		send_call(call_req(REQ_ADMIT, acct_hi, tag_ones, 16'h8000));
		send_call(call_req(REQ_ADMIT, acct_hi, tag_ones, 16'h0000));
		send_call(call_req(REQ_RELEASE, acct_hi, 32'h5A5A_5A5A, 16'h7FFF));
		send_call(call_req(REQ_RELEASE, acct_hi, tag_ones, 16'h0001));
		send_call(call_req(REQ_RELEASE, acct_hi, tag_ones, 16'h0001));
	endtask

	// Strict mode: an admit of a known call reuses its entry or meets the limit.
	task automatic test_strict_admit();
		logic [31:0] tag_a;
		logic [31:0] tag_b;
		tag_a = 32'h1234_5678;
		tag_b = 32'hEDCB_A987;
		write_strict_mode(1'b1);
		send_call(call_req(REQ_ADMIT, 8'h00, tag_a, 16'd2));
		send_call(call_req(REQ_ADMIT, 8'h00, tag_a, 16'd2));
		send_call(call_req(REQ_ADMIT, 8'h00, tag_a, 16'd2));
		send_call(call_req(REQ_ADMIT, 8'h00, tag_b, 16'd2));
		send_call(call_req(REQ_RELEASE, 8'h00, tag_a, 16'd2));
		send_call(call_req(REQ_RELEASE, 8'h00, tag_a, 16'd2));
	endtask

	// Fills the whole call table, then checks the full refusal and that the limit
	// test comes before it, and empties the table again.
	task automatic test_table_full();
		logic [31:0] fill_tag [CALL_ENTRIES];
		write_strict_mode(1'b0);
		sender_idle_pct = 0;
		for (int i = 0; i < CALL_ENTRIES; i++) begin
			fill_tag[i] = $urandom;
			send_call(call_req(REQ_ADMIT, 8'(i), fill_tag[i], 16'hFFFF));
		end
		send_call(call_req(REQ_ADMIT, 8'hC8, $urandom, 16'hFFFF));
		send_call(call_req(REQ_ADMIT, 8'h05, $urandom, 16'h0001));
		send_call(call_req(REQ_ADMIT, 8'h07, fill_tag[7], 16'h0000));
		hold_until_drained();
		for (int i = 0; i < CALL_ENTRIES; i++)
			send_call(call_req(REQ_RELEASE, 8'(i), fill_tag[i], 16'h0000));
		send_call(call_req(REQ_RELEASE, 8'h07, fill_tag[7], 16'h0000));
	endtask

	// Random traffic over a small pool of accounts and calls, so that calls come back
	// and limits bite, mixed with fully random requests.
	task automatic test_random_traffic(int count, int idle_pct, bit strict);
		logic [7:0]  acct_pool [8];
		logic [31:0] tag_pool [12];
		req_t        r;
		int          sel;
		write_strict_mode(strict);
		sender_idle_pct = idle_pct;
		acct_pool[0] = 8'h00;
		acct_pool[1] = 8'hFF;
		for (int i = 2; i < 8; i++)
			acct_pool[i] = 8'($urandom);
		tag_pool[0] = 32'h0000_0000;
		tag_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 12; i++)
			tag_pool[i] = $urandom;
		for (int n = 0; n < count; n++) begin
			r.req_type = ($urandom_range(99) < 55) ? REQ_ADMIT : REQ_RELEASE;
			if ($urandom_range(99) < 10) begin
				r.account_id = 8'($urandom);
				r.call_tag = $urandom;
			end else begin
				r.account_id = acct_pool[$urandom_range(7)];
				r.call_tag = tag_pool[$urandom_range(11)];
			end
			sel = $urandom_range(99);
			if (sel < 10)
				r.call_limit = 16'd0;
			else if (sel < 70)
				r.call_limit = 16'($urandom_range(1, 6));
			else if (sel < 85)
				r.call_limit = 16'($urandom);
			else
				r.call_limit = 16'hFFFF;
			send_call(r);
			if ($urandom_range(99) < 3)
				hold_until_drained();
		end
	endtask

	// Compares each response with the oldest expected one.
	always @(posedge clk) begin
		rsp_t exp_rsp;
		bit   have_exp;
		if (arst_n && done) begin
			have_exp = (pending_rsp.size() != 0);
			exp_rsp = '0;
			if (have_exp)
				exp_rsp = pending_rsp.pop_front();
			if (!have_exp || rsp.accepted !== exp_rsp.accepted ||
					rsp.status !== exp_rsp.status ||
					rsp.active_calls !== exp_rsp.active_calls ||
					rsp.branch_count !== exp_rsp.branch_count) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					if (!have_exp)
						$display("%0t: response with no transaction pending: %p", $realtime, rsp);
					else
						$display("%0t: response differs: expected %p, got %p",
							$realtime, exp_rsp, rsp);
				end
			end
		end
	end

	// Ends the run when nothing has been accepted or answered for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		mismatches = 0;
		sender_idle_pct = 0;
		strict_calls = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_admit_release();
		test_strict_admit();
		test_table_full();
		test_random_traffic(85, 0, 1'b0);
		test_random_traffic(85, 73, 1'b1);
		test_random_traffic(85, 28, 1'b0);

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
hdl/cca_pkg.sv
hdl/cca_ctrl.sv
hdl/cca_datapath.sv
hdl/concurrent_call_admission.sv
dv/tb_top.sv
